@@ rtl/owoc_pkg.sv @@
package owoc_pkg;

  // input field widths
  localparam int POINT_W     = 32;
  localparam int CELL_ADDR_W = 16;
  localparam int CPM_W       = 16;
  localparam int GRID_W      = 9;
  localparam int HALF_WIN_W  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_M = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 3'd5;

  // register reset values
  localparam logic [CPM_W-1:0]      CPM_RESET      = 16'd256;
  localparam logic [GRID_W-1:0]     GRID_RESET     = 9'd256;
  localparam logic [HALF_WIN_W-1:0] HALF_WIN_RESET = 4'd3;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // point minus origin, and the cell number that follows from it
  localparam int DIFF_W     = POINT_W + 1;
  // Q.8 point times Q.8 scale leaves 16 fraction bits
  localparam int CELL_SHIFT = 16;
  localparam int PROD_W     = DIFF_W + CPM_W + 1;
  // window bound arithmetic, one guard bit above the cell number
  localparam int BOUND_W    = DIFF_W + 1;

endpackage

@@ rtl/owoc_ram.sv @@
module owoc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/occupancy_window_obstacle_check_core.sv @@
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-----------------------------------------
// in_       | request   | in_valid / in_ready   | kind, cell_addr, cell_occupied, point_x/y
// out_      | result    | out_valid / out_ready | blocked
// cfg_      | write     | cfg_we                | cfg_index, cfg_wdata
//
// a map write gives no result
// a query scans n cells, up to (2*half_window+1)^2, one map read per cycle through the
//   single read port; the scan stops at the first hit, and a window wholly off the map
//   skips the scan
// after reset the block sweeps the map clear, all MAX_GRID_DIM^2 cells (65536 by default),
//   with in_ready low; configuration writes are taken during the sweep
// a finished result waits in the output register; the block returns to idle once it
//   is loaded, so a stalled consumer only holds back the next query's result
module occupancy_window_obstacle_check_core #(
  parameter int MAX_GRID_DIM    = 256,
  parameter int MAX_HALF_WINDOW = 15
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_we,
  input  logic [owoc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [owoc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  // requests
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_kind,
  input  logic [owoc_pkg::CELL_ADDR_W-1:0]        in_cell_addr,
  input  logic                                    in_cell_occupied,
  input  logic signed [owoc_pkg::POINT_W-1:0]     in_point_x,
  input  logic signed [owoc_pkg::POINT_W-1:0]     in_point_y,
  // results
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_blocked
);

  import owoc_pkg::*;

  localparam int STORE_CELLS = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int AW          = $clog2(STORE_CELLS);   // map address
  localparam int CW          = $clog2(MAX_GRID_DIM);  // column or row number
  localparam int DW          = $clog2(MAX_GRID_DIM + 1); // grid dimension

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MULX,
    S_MULY,
    S_CLMPX,
    S_CLMPY,
    S_BASE,
    S_ADDR,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  // configuration registers
  logic signed [POINT_W-1:0] origin_x_r;
  logic signed [POINT_W-1:0] origin_y_r;
  logic [CPM_W-1:0]          cpm_r;
  logic [GRID_W-1:0]         grid_w_r;
  logic [GRID_W-1:0]         grid_h_r;
  logic [HALF_WIN_W-1:0]     half_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cpm_r      <= CPM_RESET;
      grid_w_r   <= GRID_RESET;
      grid_h_r   <= GRID_RESET;
      half_win_r <= HALF_WIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:    origin_x_r <= cfg_wdata[POINT_W-1:0];
        CFG_ORIGIN_Y:    origin_y_r <= cfg_wdata[POINT_W-1:0];
        CFG_CELLS_PER_M: cpm_r      <= cfg_wdata[CPM_W-1:0];
        CFG_GRID_WIDTH:  grid_w_r   <= cfg_wdata[GRID_W-1:0];
        CFG_GRID_HEIGHT: grid_h_r   <= cfg_wdata[GRID_W-1:0];
        CFG_HALF_WINDOW: half_win_r <= cfg_wdata[HALF_WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // grid size and half window saturate at their build limits
  logic [DW-1:0]         w_eff;
  logic [DW-1:0]         h_eff;
  logic [HALF_WIN_W-1:0] hw_eff;

  assign w_eff  = (32'(grid_w_r) > 32'(MAX_GRID_DIM)) ? DW'(MAX_GRID_DIM) : DW'(grid_w_r);
  assign h_eff  = (32'(grid_h_r) > 32'(MAX_GRID_DIM)) ? DW'(MAX_GRID_DIM) : DW'(grid_h_r);
  assign hw_eff = (32'(half_win_r) > 32'(MAX_HALF_WINDOW)) ?
                  HALF_WIN_W'(MAX_HALF_WINDOW) : half_win_r;

  // sequencer state and datapath registers
  state_t                    state_r;
  logic [AW-1:0]             clr_cnt_r;
  logic signed [DIFF_W-1:0]  dx_r;
  logic signed [DIFF_W-1:0]  dy_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DIFF_W-1:0]  cell_r;
  logic                      empty_r;
  logic [CW-1:0]             xlo_r;
  logic [CW-1:0]             xhi_r;
  logic [CW-1:0]             ylo_r;
  logic [CW-1:0]             yhi_r;
  logic [CW-1:0]             x_r;
  logic [CW-1:0]             y_r;
  logic [AW-1:0]             row_r;
  logic [AW-1:0]             addr_r;
  logic                      chk_r;
  logic                      res_r;
  logic                      out_valid_r;
  logic                      out_blocked_r;

  logic in_accept;
  logic in_range;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  // writes past the end of the map are dropped
  assign in_range  = ({16'd0, in_cell_addr} < 32'(STORE_CELLS));

  // shared multiplier: x scale, y scale, then first row offset of the window
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [CPM_W:0]    mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [DIFF_W-1:0] mul_cell;

  always_comb begin
    case (state_r)
      S_MULY: begin
        mul_a = dy_r;
        mul_b = {1'b0, cpm_r};
      end
      S_BASE: begin
        mul_a = DIFF_W'(ylo_r);
        mul_b = (CPM_W + 1)'(w_eff);
      end
      default: begin
        mul_a = dx_r;
        mul_b = {1'b0, cpm_r};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  // arithmetic shift rounds toward minus infinity
  assign mul_cell = prod_r[DIFF_W+CELL_SHIFT-1:CELL_SHIFT];

  // shared clamp unit: window bounds against one map dimension
  logic [DW-1:0]             clamp_dim;
  logic signed [BOUND_W-1:0] c_ext;
  logic signed [BOUND_W-1:0] hw_ext;
  logic signed [BOUND_W-1:0] dim_m1;
  logic signed [BOUND_W-1:0] lo;
  logic signed [BOUND_W-1:0] hi;
  logic signed [BOUND_W-1:0] lo_c;
  logic signed [BOUND_W-1:0] hi_c;
  logic                      clamp_empty;

  assign clamp_dim = (state_r == S_CLMPX) ? w_eff : h_eff;

  always_comb begin
    c_ext       = BOUND_W'(cell_r);
    hw_ext      = BOUND_W'(hw_eff);
    dim_m1      = BOUND_W'(clamp_dim) - BOUND_W'(1);
    lo          = c_ext - hw_ext;
    hi          = c_ext + hw_ext;
    lo_c        = lo[BOUND_W-1] ? '0 : lo;
    hi_c        = (hi > dim_m1) ? dim_m1 : hi;
    // also covers a zero size map and a window wholly off the map
    clamp_empty = (hi_c < lo_c);
  end

  // occupancy map
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_re;
  logic          ram_rdata;
  logic          hit;

  assign ram_we    = (state_r == S_CLEAR) ||
                     (in_accept && (in_kind == KIND_WRITE) && in_range);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : AW'(in_cell_addr);
  assign ram_wdata = (state_r == S_CLEAR) ? 1'b0 : in_cell_occupied;
  assign ram_re    = (state_r == S_SCAN);

  owoc_ram #(
    .WIDTH (1),
    .DEPTH (STORE_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // read data is registered and lands in the cycle after the address
  assign hit = chk_r && ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      chk_r <= (state_r == S_SCAN);
      // a result loaded this cycle takes the place of the one leaving
      if (out_valid_r && out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(STORE_CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept && (in_kind == KIND_QUERY)) begin
            dx_r    <= DIFF_W'(in_point_x) - DIFF_W'(origin_x_r);
            dy_r    <= DIFF_W'(in_point_y) - DIFF_W'(origin_y_r);
            state_r <= S_MULX;
          end
        end
        S_MULX: begin
          prod_r  <= mul_p;
          state_r <= S_MULY;
        end
        S_MULY: begin
          cell_r  <= mul_cell;
          prod_r  <= mul_p;
          state_r <= S_CLMPX;
        end
        S_CLMPX: begin
          xlo_r   <= lo_c[CW-1:0];
          xhi_r   <= hi_c[CW-1:0];
          empty_r <= clamp_empty;
          cell_r  <= mul_cell;
          state_r <= S_CLMPY;
        end
        S_CLMPY: begin
          ylo_r <= lo_c[CW-1:0];
          yhi_r <= hi_c[CW-1:0];
          if (empty_r || clamp_empty) begin
            res_r   <= 1'b0;
            state_r <= S_RESULT;
          end else begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          prod_r  <= mul_p;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          row_r   <= prod_r[AW-1:0] + AW'(xlo_r);
          addr_r  <= prod_r[AW-1:0] + AW'(xlo_r);
          x_r     <= xlo_r;
          y_r     <= ylo_r;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            res_r   <= 1'b1;
            state_r <= S_RESULT;
          end else if (x_r == xhi_r) begin
            if (y_r == yhi_r) begin
              state_r <= S_DRAIN;
            end else begin
              // next row, back to the left edge of the window
              y_r    <= y_r + CW'(1);
              x_r    <= xlo_r;
              row_r  <= row_r + AW'(w_eff);
              addr_r <= row_r + AW'(w_eff);
            end
          end else begin
            x_r    <= x_r + CW'(1);
            addr_r <= addr_r + AW'(1);
          end
        end
        S_DRAIN: begin
          // last read still in flight
          res_r   <= hit;
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_blocked_r <= res_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_blocked = out_blocked_r;

endmodule

@@ tb/occupancy_window_obstacle_check_core_tb.sv @@
`timescale 1ns / 1ps

module occupancy_window_obstacle_check_core_tb;
  import owoc_pkg::*;

  localparam int MAP_DIM        = 256;
  localparam int MAP_CELLS      = MAP_DIM * MAP_DIM;
  localparam int HALF_WIN_MAX   = 15;
  // idle cycles with no handshake at all; the limit outlasts the sweep of all 65536 cells after reset
  localparam int WATCHDOG_LIMIT = 200000;
  // a short pause lets trailing map writes land before a register write
  localparam int DRAIN_CYCLES   = 16;
  // long enough for a stray answer from the longest query, which scans 31 * 31 cells
  localparam int TAIL_CYCLES    = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 75;
  localparam int RECENT_DEPTH   = 32;
  localparam int MAX_REPORTS    = 40;
  localparam int LONG_HOLD      = 2500;

  typedef struct {
    logic                      kind;
    logic [CELL_ADDR_W-1:0]    addr;
    logic                      occupied;
    logic signed [POINT_W-1:0] px;
    logic signed [POINT_W-1:0] py;
  } map_request_t;

  // every input known from time zero
  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index        = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata        = '0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic                      in_kind          = KIND_WRITE;
  logic [CELL_ADDR_W-1:0]    in_cell_addr     = '0;
  logic                      in_cell_occupied = 1'b0;
  logic signed [POINT_W-1:0] in_point_x       = '0;
  logic signed [POINT_W-1:0] in_point_y       = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic                      out_blocked;

  // local copy of the map and its registers, kept in step with accepted requests
  logic signed [POINT_W-1:0] map_origin_x = '0;
  logic signed [POINT_W-1:0] map_origin_y = '0;
  logic [CPM_W-1:0]          map_cpm      = CPM_RESET;
  logic [GRID_W-1:0]         map_width    = GRID_RESET;
  logic [GRID_W-1:0]         map_height   = GRID_RESET;
  logic [HALF_WIN_W-1:0]     map_half_win = HALF_WIN_RESET;
  bit                        occupancy [MAP_CELLS];

  logic expected_blocked_q [$];
  int   recent_writes [$];
  logic want_blocked;

  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int hold_requests     = 0;
  int holds_started     = 0;
  int recv_hold_cycles  = 0;
  int stalled_cycles    = 0;
  int writes_sent       = 0;
  int queries_sent      = 0;
  int answers_checked   = 0;
  int blocked_answers   = 0;
  int mismatch_count    = 0;
  int phases_run        = 0;

  always #6 clk = ~clk;

  occupancy_window_obstacle_check_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_cell_addr    (in_cell_addr),
    .in_cell_occupied(in_cell_occupied),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blocked     (out_blocked)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // floor((p - o) * cpm / 2^16), exact in 64 bits, arithmetic shift rounds toward -inf
  function automatic longint cell_of_point(input logic signed [POINT_W-1:0] p,
                                           input logic signed [POINT_W-1:0] o);
    longint diff;
    longint prod;
    diff = longint'(p) - longint'(o);
    prod = diff * longint'(map_cpm);
    return prod >>> CELL_SHIFT;
  endfunction

  // grid sizes above the store saturate
  function automatic int grid_cols();
    return (map_width > MAP_DIM) ? MAP_DIM : int'(map_width);
  endfunction

  function automatic int grid_rows();
    return (map_height > MAP_DIM) ? MAP_DIM : int'(map_height);
  endfunction

  // any occupied in-map cell inside the square around the query point
  function automatic logic window_blocked(input map_request_t r);
    longint cols;
    longint rows;
    longint hw;
    longint cx;
    longint cy;
    longint x;
    longint y;
    logic   hit;
    cols = longint'(grid_cols());
    rows = longint'(grid_rows());
    hw   = (map_half_win > HALF_WIN_MAX) ? longint'(HALF_WIN_MAX) : longint'(map_half_win);
    cx   = cell_of_point(r.px, map_origin_x);
    cy   = cell_of_point(r.py, map_origin_y);
    hit  = 1'b0;
    for (longint i = -hw; i <= hw; i++) begin
      for (longint j = -hw; j <= hw; j++) begin
        x = cx + i;
        y = cy + j;
        // cells off the map are skipped
        if (x >= 0 && x < cols && y >= 0 && y < rows && occupancy[x + y * cols])
          hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // update the map copy or queue the answer, at the edge the request is taken
  function automatic void apply_request(input map_request_t r);
    if (r.kind == KIND_WRITE) begin
      occupancy[r.addr] = r.occupied;
      writes_sent++;
      if (r.occupied) begin
        recent_writes.insert(recent_writes.size(), int'(r.addr));
        if (recent_writes.size() > RECENT_DEPTH)
          void'(recent_writes.pop_front());
      end
    end else begin
      expected_blocked_q.insert(expected_blocked_q.size(), window_blocked(r));
      queries_sent++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // a point somewhere inside map column (or row) c under the current scale
  function automatic logic signed [POINT_W-1:0] point_near(input longint c,
                                                           input logic signed [POINT_W-1:0] o);
    longint cpm;
    longint num;
    longint d;
    longint span;
    cpm = longint'(map_cpm);
    // zero scale folds every point onto cell zero, any point will do
    if (cpm == 0)
      return $urandom;
    num  = c * 65536;
    d    = (num >= 0) ? (num + cpm - 1) / cpm : -((-num) / cpm);
    span = 65536 / cpm - 1;
    d    = d + longint'($urandom_range(0, 32'(span)));
    return POINT_W'(longint'(o) + d);
  endfunction

  // mostly queries aimed at or around recently marked cells, the rest anywhere
  function automatic map_request_t random_request();
    map_request_t r;
    int cols;
    int rows;
    int hw;
    int col;
    int row;
    int pick;
    int a;
    cols       = grid_cols();
    rows       = grid_rows();
    hw         = int'(map_half_win);
    r.kind     = ($urandom_range(0, 99) < 40) ? KIND_WRITE : KIND_QUERY;
    r.addr     = CELL_ADDR_W'($urandom);
    r.occupied = ($urandom_range(0, 99) < 45);
    r.px       = $urandom;
    r.py       = $urandom;
    pick       = $urandom_range(0, 9);
    if (r.kind == KIND_WRITE) begin
      if (pick < 8 && cols > 0 && rows > 0)
        r.addr = CELL_ADDR_W'($urandom_range(0, cols - 1) +
                              $urandom_range(0, rows - 1) * cols);
    end else if (pick < 9) begin
      if (pick < 5 && recent_writes.size() > 0 && cols > 0) begin
        a   = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        col = a % cols + $urandom_range(0, 2 * hw + 2) - (hw + 1);
        row = a / cols + $urandom_range(0, 2 * hw + 2) - (hw + 1);
      end else begin
        // just past every edge included
        col = $urandom_range(0, cols + 2 * hw + 3) - (hw + 2);
        row = $urandom_range(0, rows + 2 * hw + 3) - (hw + 2);
      end
      r.px = point_near(longint'(col), map_origin_x);
      r.py = point_near(longint'(row), map_origin_y);
    end
    return r;
  endfunction

  // one request: optional idle gap, then hold valid until taken
  // valid stays high on return; the caller either sends again or drains
  task automatic send_request(input map_request_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= r.kind;
    in_cell_addr     <= r.addr;
    in_cell_occupied <= r.occupied;
    in_point_x       <= r.px;
    in_point_y       <= r.py;
    do @(posedge clk); while (!in_ready);
    apply_request(r);
  endtask

  task automatic send_write(input logic [CELL_ADDR_W-1:0] addr, input logic occupied);
    map_request_t r;
    r.kind     = KIND_WRITE;
    r.addr     = addr;
    r.occupied = occupied;
    r.px       = $urandom;
    r.py       = $urandom;
    send_request(r);
  endtask

  task automatic send_query(input logic signed [POINT_W-1:0] px,
                            input logic signed [POINT_W-1:0] py);
    map_request_t r;
    r.kind     = KIND_QUERY;
    r.addr     = CELL_ADDR_W'($urandom);
    r.occupied = 1'($urandom);
    r.px       = px;
    r.py       = py;
    send_request(r);
  endtask

  // stop offering, wait for every answer, then let trailing map writes land
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (expected_blocked_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic load_map_config(input logic signed [POINT_W-1:0] ox,
                                 input logic signed [POINT_W-1:0] oy,
                                 input logic [CPM_W-1:0] cpm,
                                 input logic [GRID_W-1:0] cols,
                                 input logic [GRID_W-1:0] rows,
                                 input logic [HALF_WIN_W-1:0] hw);
    drain_requests();
    write_register(CFG_ORIGIN_X, ox);
    write_register(CFG_ORIGIN_Y, oy);
    write_register(CFG_CELLS_PER_M, CFG_DATA_W'(cpm));
    write_register(CFG_GRID_WIDTH, CFG_DATA_W'(cols));
    write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(rows));
    write_register(CFG_HALF_WINDOW, CFG_DATA_W'(hw));
    cfg_we       <= 1'b0;
    map_origin_x  = ox;
    map_origin_y  = oy;
    map_cpm       = cpm;
    map_width     = cols;
    map_height    = rows;
    map_half_win  = hw;
  endtask

  // no idling, sender idle, receiver stalling, both
  task automatic set_idle_mode(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 66;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct  = 29;
        recv_stall_pct = 29;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic want, input logic got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("tb: mismatch at %0t: %s, expected %b, got %b", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers: origin 0, one cell per meter, 256 x 256, half window 3
  task automatic test_directed_points();
    set_idle_mode(0);
    send_query(0, 0);                                 // empty map after the sweep
    send_write(16'd0, 1'b1);
    send_query(0, 0);
    send_query(-4 * 256, 0);                          // window ends one column short
    send_query(-3 * 256, 0);                          // window just reaches column 0
    send_query(-1, -1);                               // rounds down to cell -1
    send_write(16'hffff, 1'b1);                       // last cell of the store
    send_query(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_query(32'sh8000_0000, 32'sh8000_0000);
    send_query(255 * 256 + 128, 255 * 256 + 128);
    send_query(258 * 256, 258 * 256);                 // center off the map, edge in reach
    send_query(259 * 256, 255 * 256);                 // one column too far
    send_write(16'd0, 1'b0);
    send_query(0, 0);
  endtask

  // size saturation, empty map, zero scale, extreme origins and windows
  task automatic test_map_limits();
    load_map_config(0, 0, 16'd256, 9'd0, 9'd0, 4'd3);
    send_query(0, 0);                                 // no cell in the map
    load_map_config(0, 0, 16'd256, 9'd511, 9'd511, 4'd0);
    send_query(255 * 256, 255 * 256);                 // size clamps to 256
    load_map_config(32'sh7fff_ffff, 32'sh8000_0000, 16'd0, 9'd256, 9'd256, 4'd0);
    send_write(16'd0, 1'b1);
    send_query(32'sh8000_0000, 32'sh7fff_ffff);       // zero scale lands on cell zero
    load_map_config(32'sh8000_0000, 32'sh7fff_ffff, 16'hffff, 9'd256, 9'd256, 4'd15);
    send_query(32'sh7fff_ffff, 32'sh8000_0000);       // widest differences, both off map
    send_query(32'sh8000_0000, 32'sh7fff_ffff);       // exactly on the origin
    load_map_config(0, 0, 16'd1, 9'd1, 9'd1, 4'd1);
    send_query(65535, 65535);                         // coarsest scale, still cell 0
    send_query(-1, -1);
  endtask

  // random traffic over a spread of map settings and idle patterns
  task automatic test_random_phases();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: load_map_config(0, 0, 16'd256, 9'd256, 9'd256, 4'd2);
        1: load_map_config(-5 * 256, 3 * 256, 16'd512, 9'd12, 9'd9, 4'd1);
        2: load_map_config($urandom, $urandom, 16'd256, 9'd40, 9'd40, 4'd15);
        3: load_map_config($urandom, $urandom, 16'hffff, 9'd256, 9'd1, 4'd0);
        4: load_map_config(0, 0, 16'd1, 9'd1, 9'd256, 4'd2);
        default: load_map_config($urandom, $urandom, CPM_W'($urandom_range(0, 65535)),
                                 GRID_W'($urandom_range(1, 300)),
                                 GRID_W'($urandom_range(1, 300)),
                                 HALF_WIN_W'($urandom_range(0, 7)));
      endcase
      set_idle_mode(ph);
      repeat (PHASE_ITEMS) send_request(random_request());
      phases_run++;
    end
  endtask

  // long output stall while requests keep coming, so the input side backs up
  task automatic test_output_backpressure();
    load_map_config(0, 0, 16'd256, 9'd16, 9'd16, 4'd1);
    set_idle_mode(0);
    hold_requests++;
    repeat (24) send_request(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started    <= hold_requests;
      out_ready        <= 1'b0;
      recv_hold_cycles <= LONG_HOLD - 1;
    end else if (recv_hold_cycles > 0) begin
      out_ready        <= 1'b0;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // answer checker, oldest query first
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_blocked_q.size() == 0) begin
        report_mismatch("answer with no query pending", 1'bx, out_blocked);
      end else begin
        want_blocked = expected_blocked_q.pop_front();
        answers_checked++;
        if (want_blocked)
          blocked_answers++;
        if (out_blocked !== want_blocked)
          report_mismatch("blocked flag", want_blocked, out_blocked);
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired after %0d cycles with no handshake", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    // single reset; the block then sweeps its map with in_ready low
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_points();
    test_map_limits();
    test_random_phases();
    test_output_backpressure();
    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d map writes and %0d queries, %0d answers checked (%0d blocked)",
             writes_sent, queries_sent, answers_checked, blocked_answers);
    $display("summary: %0d random map settings, four idle patterns, one long output hold",
             phases_run);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
